FILE: hw/rtl/hcr_pkg.sv
package hcr_pkg;

	// Vertical smoothing window
	localparam int SMOOTH_TAPS      = 7;
	localparam int HALF_TAPS        = SMOOTH_TAPS / 2;
	localparam int LAG_ROWS         = HALF_TAPS + 1;
	localparam int TAP_W            = $clog2(SMOOTH_TAPS);
	localparam int CNT_W            = TAP_W + 1;
	localparam int WEIGHT_FRAC_BITS = 16;
	localparam int KEEP_FRAC        = 8;
	localparam int RND_SHIFT        = WEIGHT_FRAC_BITS - KEEP_FRAC;
	localparam int WGT_W            = 17;

	// Frame geometry
	localparam int MIN_SIZE  = 8;
	localparam int ROW_W     = 12;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 12;
	localparam int SENS_W    = 16;
	localparam int PIX_W     = 8;

	// Product entry: {xy, yy, xx}
	localparam int SQ_W   = 16;
	localparam int XY_W   = 17;
	localparam int PROD_W = 2 * SQ_W + XY_W;

	// Response arithmetic widths
	localparam int ACC_W  = 35;
	localparam int A_W    = ACC_W + 1 - RND_SHIFT;
	localparam int MUL_W  = 2 * A_W;
	localparam int DET_W  = MUL_W + 1;
	localparam int T_W    = A_W + 1;
	localparam int T2_W   = 2 * T_W;
	localparam int HI_W   = T2_W - 16 + SENS_W;
	localparam int AT2_W  = HI_W + 1;
	localparam int DIFF_W = ((DET_W > AT2_W) ? DET_W : AT2_W) + 1;
	localparam int RS_W   = DIFF_W + 1 - 16;
	localparam int RESP_W = 36;

	// Configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS   = 2'd2;
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd480;
	localparam logic [SENS_W-1:0]   SENS_RST   = 16'd2621;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRD,
		ST_PWR,
		ST_ACC,
		ST_MATH,
		ST_OUT,
		ST_ADV
	} hcr_state_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] sxx;
		logic signed [ACC_W-1:0] syy;
		logic signed [ACC_W-1:0] sxy;
	} hcr_sums_t;

	// Gaussian sigma 1, Q0.16, sums to 65536
	function automatic logic [WGT_W-1:0] gauss_w(input logic [TAP_W-1:0] k);
		case (k)
			3'd0:    gauss_w = 17'd291;
			3'd1:    gauss_w = 17'd3539;
			3'd2:    gauss_w = 17'd15862;
			3'd3:    gauss_w = 17'd26152;
			3'd4:    gauss_w = 17'd15862;
			3'd5:    gauss_w = 17'd3539;
			3'd6:    gauss_w = 17'd291;
			default: gauss_w = 17'd0;
		endcase
	endfunction

	// Reduce a value below three times the tap count into a tap slot
	function automatic logic [TAP_W-1:0] wrap_tap(input logic [TAP_W+1:0] v);
		logic [TAP_W+1:0] r;
		r = v;
		if (r >= (TAP_W+2)'(2 * SMOOTH_TAPS))
			r = r - (TAP_W+2)'(2 * SMOOTH_TAPS);
		else if (r >= (TAP_W+2)'(SMOOTH_TAPS))
			r = r - (TAP_W+2)'(SMOOTH_TAPS);
		wrap_tap = r[TAP_W-1:0];
	endfunction

	function automatic logic [1:0] dec3(input logic [1:0] v);
		dec3 = (v == 2'd0) ? 2'd2 : v - 2'd1;
	endfunction

	function automatic logic [1:0] inc3(input logic [1:0] v);
		inc3 = (v == 2'd2) ? 2'd0 : v + 2'd1;
	endfunction

endpackage

FILE: hw/rtl/hcr_resp.sv
module hcr_resp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  hcr_pkg::hcr_sums_t                 sums,
	input  logic [hcr_pkg::SENS_W-1:0]         sens,
	output logic                               done,
	output logic signed [hcr_pkg::RESP_W-1:0]  resp
);
	import hcr_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [ACC_W:0]    rxx, ryy, rxy;
	logic signed [ACC_W:0]    sh_xx, sh_yy, sh_xy;
	logic signed [A_W-1:0]    a_s1, b_s1, x_s1;
	logic signed [MUL_W-1:0]  ab_s2, xsq_s2;
	logic signed [T_W-1:0]    t_s2;
	logic signed [DET_W-1:0]  det_s3, det_s4;
	logic signed [T2_W-1:0]   t2_s3;
	logic [T2_W-17:0]         t2_hi;
	logic [HI_W-1:0]          hi_s4;
	logic [31:0]              lo_s4;
	logic [32:0]              lo_r;
	logic [AT2_W-1:0]         at2;
	logic signed [DIFF_W-1:0] det_x, at2_x, diff_s5;
	logic signed [DIFF_W:0]   rr;
	logic signed [DIFF_W:0]   rr_sh;
	logic signed [RS_W-1:0]   rs;
	logic                     fits;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Round smoothed sums to Q.8, half up
	always_comb begin
		rxx   = {sums.sxx[ACC_W-1], sums.sxx} + (ACC_W+1)'(1 << (RND_SHIFT - 1));
		ryy   = {sums.syy[ACC_W-1], sums.syy} + (ACC_W+1)'(1 << (RND_SHIFT - 1));
		rxy   = {sums.sxy[ACC_W-1], sums.sxy} + (ACC_W+1)'(1 << (RND_SHIFT - 1));
		sh_xx = rxx >>> RND_SHIFT;
		sh_yy = ryy >>> RND_SHIFT;
		sh_xy = rxy >>> RND_SHIFT;
	end

	always_ff @(posedge clk) begin
		a_s1 <= sh_xx[A_W-1:0];
		b_s1 <= sh_yy[A_W-1:0];
		x_s1 <= sh_xy[A_W-1:0];
	end

	// Products of the structure tensor and the trace
	always_ff @(posedge clk) begin
		ab_s2  <= a_s1 * b_s1;
		xsq_s2 <= x_s1 * x_s1;
		t_s2   <= a_s1 + b_s1;
	end

	always_ff @(posedge clk) begin
		det_s3 <= ab_s2 - xsq_s2;
		t2_s3  <= t_s2 * t_s2;
	end

	// alpha * trace^2, split at bit 16
	assign t2_hi = t2_s3[T2_W-1:16];

	always_ff @(posedge clk) begin
		hi_s4  <= t2_hi * sens;
		lo_s4  <= t2_s3[15:0] * sens;
		det_s4 <= det_s3;
	end

	always_comb begin
		lo_r  = {1'b0, lo_s4} + 33'd32768;
		at2   = AT2_W'(hi_s4) + AT2_W'(lo_r[32:16]);
		det_x = DIFF_W'(det_s4);
		at2_x = {{(DIFF_W - AT2_W){1'b0}}, at2};
	end

	always_ff @(posedge clk) begin
		diff_s5 <= det_x - at2_x;
	end

	// Round to integer and saturate
	always_comb begin
		rr    = {diff_s5[DIFF_W-1], diff_s5} + (DIFF_W+1)'(32768);
		rr_sh = rr >>> 16;
		rs    = rr_sh[RS_W-1:0];
		fits  = (&rs[RS_W-1:RESP_W-1]) || !(|rs[RS_W-1:RESP_W-1]);
		if (fits)
			resp = rs[RESP_W-1:0];
		else if (rs[RS_W-1])
			resp = {1'b1, {(RESP_W-1){1'b0}}};
		else
			resp = {1'b0, {(RESP_W-1){1'b1}}};
	end

	assign done = v_s5;

	property p_one_in_flight;
		@(posedge clk) disable iff (!arst_n)
		start |=> !start;
	endproperty
	a_one_in_flight: assert property (p_one_in_flight)
		else $error("back-to-back start on response pipeline");

	property p_done_latency;
		@(posedge clk) disable iff (!arst_n)
		v_s1 |-> ##4 done;
	endproperty
	a_done_latency: assert property (p_done_latency)
		else $error("response pipeline latency broken");

	property p_done_pulse;
		@(posedge clk) disable iff (!arst_n)
		done |=> !done;
	endproperty
	a_done_pulse: assert property (p_done_pulse)
		else $error("done held longer than one cycle");

endmodule

FILE: hw/rtl/harris_corner_response.sv
// Harris corner response over a raster stream of 8-bit gray pixels, one result per
// pixel, lagging the input by four rows; flush requests drain the last four rows of a
// frame after its final pixel. Gradients are central differences, the three products
// are smoothed by a 7-tap vertical Gaussian (Q0.16), and the response is
// det - alpha*trace^2 rounded and saturated to 36 bits. Borders mirror without repeating
// the edge pixel. A sequencer walks each request through two single-port line stores
// (three pixel rows, seven product rows): a pixel request steps through four pixel
// reads, one product write, seven product reads, a five-stage response pipeline, output
// load and counter update; a flush request skips the pixel reads and product write;
// the last pixel of a frame adds a sweep that forms the bottom product row. A finished
// result waits in the output register while the next request is taken. Changing width
// or height restarts the frame; sensitivity applies from the next result on.
module harris_corner_response #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pix_valid,
	output logic                                  pix_ready,
	input  logic                                  action,
	input  logic [hcr_pkg::PIX_W-1:0]             pixel,
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic signed [hcr_pkg::RESP_W-1:0]     response,
	output logic                                  row_end,
	output logic                                  frame_end,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hcr_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [hcr_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import hcr_pkg::*;

	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int EW        = $clog2(MAX_WIDTH + 1);
	localparam int PIX_DEPTH = 3 * MAX_WIDTH;
	localparam int PA_W      = $clog2(PIX_DEPTH);
	localparam int PRD_DEPTH = SMOOTH_TAPS * MAX_WIDTH;
	localparam int QA_W      = $clog2(PRD_DEPTH);

	// Configuration
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [SENS_W-1:0]   sens_q;
	logic                cfg_wr, cfg_dim_wr;
	logic [EW-1:0]       w_eff;
	logic [ROW_W-1:0]    h_eff;

	// Sequencer
	hcr_state_t        state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              act_q;
	logic              sweep_q;
	logic [COL_W-1:0]  pc_q;

	// Frame counters
	logic [ROW_W-1:0]  in_row_q, out_row_q;
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [1:0]        in_m3_q;
	logic [TAP_W-1:0]  in_m7_q, out_m7_q, last_m7_q;

	// Memories
	logic [PIX_W-1:0]  pix_mem [PIX_DEPTH];
	logic [PROD_W-1:0] prod_mem [PRD_DEPTH];
	logic              pix_we, pix_re, q_we, q_re;
	logic [PA_W-1:0]   pix_waddr, pix_raddr;
	logic [QA_W-1:0]   q_waddr, q_raddr;
	logic [PIX_W-1:0]  pix_rdata_q;
	logic [PROD_W-1:0] q_rdata_q, q_wdata;
	logic [1:0]        pix_rsel;
	logic [COL_W-1:0]  pix_rcol;
	logic [TAP_W-1:0]  q_wslot, q_rslot;

	// Datapath
	logic [PIX_W-1:0]          pr_q, pl_q, pu_q;
	logic signed [PIX_W:0]     ix, iy;
	logic signed [2*PIX_W+1:0] ixx, iyy, ixy;
	logic [COL_W-1:0]          col_left, col_right;
	logic [1:0]                sel_p, sel_u, sel_d;
	logic [ROW_W:0]            tap_s, tap_d;
	logic [TAP_W-1:0]          acc_k, tap_w_idx;
	logic [WGT_W-1:0]          wgt;
	logic signed [ACC_W-1:0]   mxx, myy, mxy;
	hcr_sums_t                 sums_q;
	logic                      go_math_q;
	logic                      math_done;
	logic signed [RESP_W-1:0]  math_resp, resp_hold_q;
	logic                      res_load;

	// Decoded conditions
	logic pix_acc, col_last, row_last, pc_last, row_ge_h, out_re, out_fe;

	assign cfg_ready  = 1'b1;
	assign cfg_wr     = cfg_valid && cfg_ready;
	assign cfg_dim_wr = cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			sens_q   <= SENS_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= cfg_data[HEIGHT_W-1:0];
				REG_SENS:   sens_q   <= cfg_data[SENS_W-1:0];
				default:    ;
			endcase
		end
	end

	// Clamp geometry; 12-bit height already stays under the upper limit
	always_comb begin
		if (width_q < WIDTH_W'(MIN_SIZE))
			w_eff = EW'(MIN_SIZE);
		else if (32'(width_q) > MAX_WIDTH)
			w_eff = EW'(MAX_WIDTH);
		else
			w_eff = EW'(width_q);
		h_eff = (height_q < HEIGHT_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : height_q;
	end

	always_comb begin
		pix_acc  = pix_valid && pix_ready;
		row_ge_h = in_row_q >= h_eff;
		col_last = (EW'(in_col_q) + EW'(1)) >= w_eff;
		row_last = ({1'b0, in_row_q} + (ROW_W+1)'(1)) >= {1'b0, h_eff};
		pc_last  = (EW'(pc_q) + EW'(1)) >= w_eff;
		out_re   = (EW'(out_col_q) + EW'(1)) >= w_eff;
		out_fe   = out_re && (({1'b0, out_row_q} + (ROW_W+1)'(1)) >= {1'b0, h_eff});
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pix_valid) begin
					if (action) begin
						if (row_ge_h)
							state_d = ST_ACC;
					end else if (!row_ge_h) begin
						state_d = (in_row_q == '0) ? ST_ADV : ST_PRD;
					end
				end
			end
			ST_PRD: begin
				if (cnt_q == CNT_W'(3))
					state_d = ST_PWR;
			end
			ST_PWR: begin
				if (sweep_q)
					state_d = pc_last ? ST_IDLE : ST_PRD;
				else
					state_d = (in_row_q >= ROW_W'(LAG_ROWS)) ? ST_ACC : ST_ADV;
			end
			ST_ACC: begin
				if (cnt_q == CNT_W'(SMOOTH_TAPS))
					state_d = ST_MATH;
			end
			ST_MATH: begin
				if (math_done)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!res_valid || res_ready)
					state_d = act_q ? ST_IDLE : ST_ADV;
			end
			ST_ADV: begin
				state_d = (col_last && row_last) ? ST_PRD : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Row selects and mirrored column neighbors for product forming
	always_comb begin
		if (sweep_q) begin
			sel_p = in_m3_q;
			sel_u = dec3(in_m3_q);
			sel_d = dec3(in_m3_q);
		end else begin
			sel_p = dec3(in_m3_q);
			sel_u = (in_row_q == ROW_W'(1)) ? in_m3_q : inc3(in_m3_q);
			sel_d = in_m3_q;
		end
		col_left  = (pc_q == '0) ? COL_W'(1) : pc_q - COL_W'(1);
		col_right = ((EW'(pc_q) + EW'(1)) >= w_eff) ? COL_W'(w_eff - EW'(2))
		                                           : pc_q + COL_W'(1);
	end

	// Mirrored product row for smoothing tap
	always_comb begin
		acc_k = cnt_q[TAP_W-1:0];
		tap_s = {1'b0, out_row_q} + (ROW_W+1)'(acc_k);
		tap_d = tap_s - {1'b0, h_eff} - (ROW_W+1)'(HALF_TAPS - 1);
		if (tap_s < (ROW_W+1)'(HALF_TAPS))
			q_rslot = TAP_W'((ROW_W+1)'(HALF_TAPS) - tap_s);
		else if (tap_s > ({1'b0, h_eff} + (ROW_W+1)'(HALF_TAPS - 1)))
			q_rslot = wrap_tap((TAP_W+2)'(last_m7_q) + (TAP_W+2)'(SMOOTH_TAPS)
			                   - tap_d[TAP_W+1:0]);
		else
			q_rslot = wrap_tap((TAP_W+2)'(out_m7_q) + (TAP_W+2)'(acc_k)
			                   + (TAP_W+2)'(SMOOTH_TAPS - HALF_TAPS));
		q_wslot = sweep_q ? in_m7_q
		                  : wrap_tap((TAP_W+2)'(in_m7_q) + (TAP_W+2)'(SMOOTH_TAPS - 1));
	end

	// Gradient products
	always_comb begin
		ix      = $signed({1'b0, pr_q}) - $signed({1'b0, pl_q});
		iy      = $signed({1'b0, pix_rdata_q}) - $signed({1'b0, pu_q});
		ixx     = ix * ix;
		iyy     = iy * iy;
		ixy     = ix * iy;
		q_wdata = {ixy[XY_W-1:0], iyy[SQ_W-1:0], ixx[SQ_W-1:0]};
	end

	// Memory and handshake controls
	always_comb begin
		pix_ready = (state_q == ST_IDLE);
		pix_we    = 1'b0;
		pix_re    = 1'b0;
		pix_rsel  = sel_p;
		pix_rcol  = col_right;
		q_we      = 1'b0;
		q_re      = 1'b0;
		res_load  = 1'b0;
		case (state_q)
			ST_IDLE: pix_we = pix_acc && !action && !row_ge_h;
			ST_PRD: begin
				pix_re = 1'b1;
				case (cnt_q)
					CNT_W'(0): begin
						pix_rsel = sel_p;
						pix_rcol = col_right;
					end
					CNT_W'(1): begin
						pix_rsel = sel_p;
						pix_rcol = col_left;
					end
					CNT_W'(2): begin
						pix_rsel = sel_u;
						pix_rcol = pc_q;
					end
					default: begin
						pix_rsel = sel_d;
						pix_rcol = pc_q;
					end
				endcase
			end
			ST_PWR:  q_we = 1'b1;
			ST_ACC:  q_re = cnt_q < CNT_W'(SMOOTH_TAPS);
			ST_OUT:  res_load = !res_valid || res_ready;
			default: ;
		endcase
		pix_waddr = PA_W'(in_m3_q) * PA_W'(MAX_WIDTH) + PA_W'(in_col_q);
		pix_raddr = PA_W'(pix_rsel) * PA_W'(MAX_WIDTH) + PA_W'(pix_rcol);
		q_waddr   = QA_W'(q_wslot) * QA_W'(MAX_WIDTH) + QA_W'(pc_q);
		q_raddr   = QA_W'(q_rslot) * QA_W'(MAX_WIDTH) + QA_W'(out_col_q);
	end

	// Pixel row store
	always_ff @(posedge clk) begin
		if (pix_we)
			pix_mem[pix_waddr] <= pixel;
		if (pix_re)
			pix_rdata_q <= pix_mem[pix_raddr];
	end

	// Product row store
	always_ff @(posedge clk) begin
		if (q_we)
			prod_mem[q_waddr] <= q_wdata;
		if (q_re)
			q_rdata_q <= prod_mem[q_raddr];
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			go_math_q <= 1'b0;
		end else begin
			state_q   <= cfg_dim_wr ? ST_IDLE : state_d;
			cnt_q     <= (state_d != state_q) ? '0 : cnt_q + CNT_W'(1);
			go_math_q <= (state_q == ST_ACC) && (cnt_q == CNT_W'(SMOOTH_TAPS));
		end
	end

	// Neighbor capture for gradients
	always_ff @(posedge clk) begin
		if (state_q == ST_PRD) begin
			if (cnt_q == CNT_W'(1))
				pr_q <= pix_rdata_q;
			if (cnt_q == CNT_W'(2))
				pl_q <= pix_rdata_q;
			if (cnt_q == CNT_W'(3))
				pu_q <= pix_rdata_q;
		end
	end

	// Weighted vertical sums
	always_comb begin
		tap_w_idx = TAP_W'(cnt_q - CNT_W'(1));
		wgt       = gauss_w(tap_w_idx);
		mxx       = $signed({1'b0, wgt}) * $signed({1'b0, q_rdata_q[SQ_W-1:0]});
		myy       = $signed({1'b0, wgt}) * $signed({1'b0, q_rdata_q[2*SQ_W-1:SQ_W]});
		mxy       = $signed({1'b0, wgt}) * $signed(q_rdata_q[PROD_W-1:2*SQ_W]);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ACC) begin
			if (cnt_q == '0) begin
				sums_q <= '0;
			end else begin
				sums_q.sxx <= sums_q.sxx + mxx;
				sums_q.syy <= sums_q.syy + myy;
				sums_q.sxy <= sums_q.sxy + mxy;
			end
		end
	end

	hcr_resp u_resp (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (go_math_q),
		.sums   (sums_q),
		.sens   (sens_q),
		.done   (math_done),
		.resp   (math_resp)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_MATH && math_done)
			resp_hold_q <= math_resp;
	end

	// Request kind, product column, frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q     <= 1'b0;
			sweep_q   <= 1'b0;
			pc_q      <= '0;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_m3_q   <= '0;
			in_m7_q   <= '0;
			out_m7_q  <= '0;
			last_m7_q <= '0;
		end else if (cfg_dim_wr) begin
			sweep_q   <= 1'b0;
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			in_m3_q   <= '0;
			in_m7_q   <= '0;
			out_m7_q  <= '0;
		end else begin
			if (state_q == ST_IDLE && pix_acc) begin
				act_q <= action;
				pc_q  <= in_col_q;
			end
			// bottom row sweep steps column by column
			if (state_q == ST_PWR && sweep_q) begin
				if (pc_last) begin
					sweep_q   <= 1'b0;
					in_row_q  <= in_row_q + ROW_W'(1);
					last_m7_q <= in_m7_q;
				end else begin
					pc_q <= pc_q + COL_W'(1);
				end
			end
			if (state_q == ST_ADV) begin
				if (col_last) begin
					in_col_q <= '0;
					if (row_last) begin
						sweep_q <= 1'b1;
						pc_q    <= '0;
					end else begin
						in_row_q <= in_row_q + ROW_W'(1);
						in_m3_q  <= inc3(in_m3_q);
						in_m7_q  <= wrap_tap((TAP_W+2)'(in_m7_q) + (TAP_W+2)'(1));
					end
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
			end
			if (res_load) begin
				if (out_fe) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					in_m3_q   <= '0;
					in_m7_q   <= '0;
					out_m7_q  <= '0;
				end else if (out_re) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + ROW_W'(1);
					out_m7_q  <= wrap_tap((TAP_W+2)'(out_m7_q) + (TAP_W+2)'(1));
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			response  <= resp_hold_q;
			row_end   <= out_re;
			frame_end <= out_fe;
		end
	end

	property p_out_behind_in;
		@(posedge clk) disable iff (!arst_n)
		out_row_q <= in_row_q;
	endproperty
	a_out_behind_in: assert property (p_out_behind_in)
		else $error("output row ahead of input row");

	property p_frame_restart;
		@(posedge clk) disable iff (!arst_n)
		(res_load && out_fe) |=> (in_row_q == '0 && out_row_q == '0 && in_col_q == '0);
	endproperty
	a_frame_restart: assert property (p_frame_restart)
		else $error("counters not cleared after last result of frame");

	property p_sweep_row;
		@(posedge clk) disable iff (!arst_n)
		sweep_q |-> ({1'b0, in_row_q} + (ROW_W+1)'(1)) == {1'b0, h_eff};
	endproperty
	a_sweep_row: assert property (p_sweep_row)
		else $error("bottom row sweep outside last input row");

	property p_slot_range;
		@(posedge clk) disable iff (!arst_n)
		in_m7_q < TAP_W'(SMOOTH_TAPS) && out_m7_q < TAP_W'(SMOOTH_TAPS) && in_m3_q != 2'd3;
	endproperty
	a_slot_range: assert property (p_slot_range)
		else $error("row slot counter out of range");

endmodule

FILE: test/testbench.sv
module testbench;
	import hcr_pkg::*;

	localparam int MAXW       = 1024;
	localparam int DRAIN_WAIT = 300;
	localparam int STALL_LIMIT = 60000;
	localparam int HOLD_LEN   = 1500;
	localparam int ITEM_GOAL  = 1550;
	localparam longint GW [0:6] = '{291, 3539, 15862, 26152, 15862, 3539, 291};
	localparam bit ACT_PIXEL = 1'b0;
	localparam bit ACT_FLUSH = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct {
		logic signed [RESP_W-1:0] response;
		logic                     row_end;
		logic                     frame_end;
	} corner_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	logic action = 1'b0;
	logic [PIX_W-1:0] pixel = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	logic signed [RESP_W-1:0] response;
	logic row_end, frame_end;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	harris_corner_response dut (.*);

	// predictor state
	byte unsigned pix_mem [0:3*MAXW-1];
	int unsigned  sq_x [0:7*MAXW-1];
	int unsigned  sq_y [0:7*MAXW-1];
	int           cross_xy [0:7*MAXW-1];
	int unsigned  in_r, in_c, out_r, out_c;
	int unsigned  img_w, img_h, alpha;

	corner_t expected_q [$];
	int errors = 0;
	int sent = 0;
	int send_idle = 0;
	int recv_stall = 0;
	bit hold_req = 1'b0;
	int hold_cnt = 0;

	initial forever #4 clk = ~clk;

	function automatic int unsigned eff_w();
		return (img_w < MIN_SIZE) ? MIN_SIZE : (img_w > MAXW) ? MAXW : img_w;
	endfunction

	function automatic int unsigned eff_h();
		return (img_h < MIN_SIZE) ? MIN_SIZE : (img_h > 4095) ? 4095 : img_h;
	endfunction

	function automatic int pix_at(int unsigned r, int unsigned c);
		return pix_mem[(r % 3) * MAXW + (c % MAXW)];
	endfunction

	// gradient products for one pixel of row p
	function automatic void form_grad(int unsigned p, int unsigned c, int unsigned w,
			int unsigned h);
		int unsigned lf, rt, up, dn, slot;
		int ix, iy;
		lf = (c == 0) ? 1 : c - 1;
		rt = (c + 1 >= w) ? w - 2 : c + 1;
		up = (p == 0) ? 1 : p - 1;
		dn = (p + 1 >= h) ? p - 1 : p + 1;
		ix = pix_at(p, rt) - pix_at(p, lf);
		iy = pix_at(dn, c) - pix_at(up, c);
		slot = (p % 7) * MAXW + (c % MAXW);
		sq_x[slot] = (ix * ix) & 16'hFFFF;
		sq_y[slot] = (iy * iy) & 16'hFFFF;
		cross_xy[slot] = ix * iy;
	endfunction

	function automatic longint harris_resp(int unsigned r, int unsigned c, int unsigned h);
		longint sxx, syy, sxy, m, a, b, x, det, resp;
		longint unsigned t, t2, hi, lo, at2;
		int unsigned slot;
		sxx = 0; syy = 0; sxy = 0;
		for (int k = 0; k < 7; k++) begin
			m = longint'(r) + k - 3;
			if (m < 0) m = -m;
			if (m > longint'(h) - 1) m = 2 * (longint'(h) - 1) - m;
			slot = (int'(m) % 7) * MAXW + (c % MAXW);
			sxx += GW[k] * sq_x[slot];
			syy += GW[k] * sq_y[slot];
			sxy += GW[k] * cross_xy[slot];
		end
		a = (sxx + 128) >>> 8;
		b = (syy + 128) >>> 8;
		x = (sxy + 128) >>> 8;
		det = a * b - x * x;
		t = a + b;
		t2 = t * t;
		hi = (t2 >> 16) * alpha;
		lo = (t2 & 64'hFFFF) * alpha;
		at2 = hi + ((lo + 32768) >> 16);
		resp = (det - longint'(at2) + 32768) >>> 16;
		if (resp > 64'sd34359738367) resp = 64'sd34359738367;
		if (resp < -64'sd34359738368) resp = -64'sd34359738368;
		return resp;
	endfunction

	function automatic void emit_result(int unsigned w, int unsigned h);
		corner_t e;
		e.response = RESP_W'(harris_resp(out_r, out_c, h));
		e.row_end = (out_c + 1 >= w);
		e.frame_end = e.row_end && (out_r + 1 >= h);
		expected_q.push_back(e);
		if (e.frame_end) begin
			in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		end else if (e.row_end) begin
			out_c = 0;
			out_r++;
		end else begin
			out_c++;
		end
	endfunction

	function automatic void predict_item(bit act, int unsigned pv);
		int unsigned w, h;
		w = eff_w();
		h = eff_h();
		if (act == ACT_FLUSH) begin
			if (in_r >= h) emit_result(w, h);
			return;
		end
		if (in_r >= h) return;
		pix_mem[(in_r % 3) * MAXW + (in_c % MAXW)] = pv[7:0];
		if (in_r >= 1) form_grad(in_r - 1, in_c, w, h);
		if (in_r >= LAG_ROWS) emit_result(w, h);
		if (in_c + 1 >= w) begin
			if (in_r + 1 >= h) begin
				for (int unsigned c = 0; c < w; c++) form_grad(h - 1, c, w, h);
				in_r = h;
			end else begin
				in_r++;
			end
			in_c = 0;
		end else begin
			in_c++;
		end
	endfunction

	function automatic void predict_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
		case (idx)
			REG_WIDTH: begin
				img_w = v & 11'h7FF;
				in_r = 0; in_c = 0; out_r = 0; out_c = 0;
			end
			REG_HEIGHT: begin
				img_h = v & 12'hFFF;
				in_r = 0; in_c = 0; out_r = 0; out_c = 0;
			end
			REG_SENS: alpha = v & 16'hFFFF;
			default: ;
		endcase
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// one request on the pixel channel; valid stays up for a following request
	task automatic send_item(bit act, int unsigned pv);
		@(negedge clk);
		if ($urandom_range(99) < send_idle) begin
			pix_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		pix_valid = 1'b1;
		action = act;
		pixel = pv[7:0];
		do @(posedge clk); while (!pix_ready);
		predict_item(act, pv);
		sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		pix_valid = 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
		wait_drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = v[15:0];
		do @(posedge clk); while (!cfg_ready);
		predict_reg(idx, v);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic int unsigned pick_pixel(int r, int c, int style);
		case (style)
			0: return $urandom_range(255);
			1: return ((r + c) % 2) ? 255 : 0;
			2: return ($urandom_range(1)) ? 255 : 0;
			default: return (r * 37 + c * 11 + $urandom_range(20)) & 8'hFF;
		endcase
	endfunction

	// whole frame, then flush requests until the frame end is drained
	task automatic run_frame(int style, bit noisy);
		int unsigned w, h;
		w = eff_w();
		h = eff_h();
		for (int r = 0; r < h; r++) begin
			for (int c = 0; c < w; c++) begin
				if (noisy && $urandom_range(29) == 0) send_item(ACT_FLUSH, $urandom_range(255));
				send_item(ACT_PIXEL, pick_pixel(r, c, style));
			end
		end
		if (noisy) send_item(ACT_PIXEL, $urandom_range(255));
		while (in_r == h) begin
			send_item(ACT_FLUSH, $urandom_range(255));
			if (noisy && in_r == h && $urandom_range(9) == 0)
				send_item(ACT_PIXEL, $urandom_range(255));
		end
	endtask

	// broken frame: n pixel or flush requests, then cut short by a geometry write
	task automatic run_partial(int unsigned n);
		for (int i = 0; i < n; i++) send_item($urandom_range(7) == 0, $urandom_range(255));
	endtask

	task automatic test_directed();
		write_reg(REG_WIDTH, 8);
		write_reg(REG_HEIGHT, 8);
		write_reg(REG_SENS, 65535);
		send_item(ACT_FLUSH, 0);
		run_frame(1, 1'b0);
		write_reg(REG_SENS, 0);
		run_frame(2, 1'b1);
	endtask

	task automatic test_register_extremes();
		write_reg(REG_WIDTH, 16'hFFFF);
		run_partial(20);
		write_reg(REG_WIDTH, 0);
		write_reg(REG_HEIGHT, 0);
		write_reg(REG_SENS, 2621);
		write_reg(REG_NONE, 16'hFFFF);
		run_frame(0, 1'b0);
		write_reg(REG_HEIGHT, 4095);
		run_partial(56);
		write_reg(REG_HEIGHT, 9);
		write_reg(REG_WIDTH, 1024);
		run_partial(30);
		write_reg(REG_WIDTH, 11);
		run_frame(3, 1'b1);
	endtask

	task automatic test_random_phase(int sidle, int rstall, int goal);
		send_idle = sidle;
		recv_stall = rstall;
		while (sent < goal) begin
			write_reg(REG_SENS, ($urandom_range(3) == 0) ? $urandom_range(65535)
				: $urandom_range(4000));
			if ($urandom_range(3) == 0) write_reg(REG_NONE, $urandom_range(65535));
			write_reg(REG_WIDTH, ($urandom_range(9) == 0) ? $urandom_range(24, 40)
				: $urandom_range(8, 14));
			write_reg(REG_HEIGHT, $urandom_range(8, 11));
			if ($urandom_range(5) == 0)
				run_partial($urandom_range(10, 60));
			else
				run_frame($urandom_range(3), $urandom_range(2) == 0);
		end
	endtask

	task automatic test_backpressure();
		send_idle = 0;
		recv_stall = 0;
		write_reg(REG_WIDTH, 8);
		write_reg(REG_HEIGHT, 8);
		hold_req = 1'b1;
		run_frame(0, 1'b0);
		wait_drain();
		run_frame(2, 1'b0);
	endtask

	// result side: ready pattern and the long hold-off
	always @(negedge clk) begin
		if (hold_req) begin
			hold_cnt = HOLD_LEN;
			hold_req = 1'b0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		corner_t e;
		if (arst_n && res_valid && res_ready) begin
			if (expected_q.size() == 0) begin
				report("unexpected result", response, 0);
			end else begin
				e = expected_q.pop_front();
				if (response !== e.response) report("response", response, e.response);
				if (row_end !== e.row_end) report("row_end", row_end, e.row_end);
				if (frame_end !== e.frame_end) report("frame_end", frame_end, e.frame_end);
			end
		end
	end

	// stall watchdog
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int phase_len;
		img_w = 640; img_h = 480; alpha = 2621;
		in_r = 0; in_c = 0; out_r = 0; out_c = 0;
		foreach (pix_mem[i]) pix_mem[i] = 0;
		foreach (sq_x[i]) begin
			sq_x[i] = 0; sq_y[i] = 0; cross_xy[i] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_register_extremes();
		test_backpressure();
		// random phases share what is left of the item budget; each may overrun by the rest of its last run
		phase_len = (ITEM_GOAL - sent) / 4 - 60;
		if (phase_len < 40) phase_len = 40;
		test_random_phase(0, 0, sent + phase_len);
		test_random_phase(53, 0, sent + phase_len);
		test_random_phase(0, 53, sent + phase_len);
		test_random_phase(18, 18, sent + phase_len);
		wait_drain();
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
